### rtl/core/rid_pkg.sv
package rid_pkg;

	localparam int POOL_SLOTS = 8;
	localparam int RING_DEPTH = 32;
	localparam int ID_BITS    = 64;

	localparam int CONV_BITS  = 64;
	localparam int TAG_BITS   = 64;
	localparam int SLOT_OUT_W = 3;
	localparam int IN_W       = CONV_BITS + TAG_BITS;
	localparam int OUT_W      = 8;

	localparam int SLOT_W     = $clog2(POOL_SLOTS);
	localparam int RANK_W     = SLOT_W;
	localparam int POS_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int RING_WORDS = POOL_SLOTS * RING_DEPTH;
	localparam int RING_AW    = $clog2(RING_WORDS);

	typedef struct packed {
		logic              dup;
		logic [SLOT_W-1:0] slot;
		logic              reassigned;
	} result_t;

endpackage

### rtl/core/rid_ram.sv
module rid_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/rid_ctrl.sv
module rid_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rid_pkg::CONV_BITS-1:0]    conv_in,
	input  logic [rid_pkg::ID_BITS-1:0]      id_in,
	output logic                             conv_we,
	output logic [rid_pkg::SLOT_W-1:0]       conv_waddr,
	output logic [rid_pkg::CONV_BITS-1:0]    conv_wdata,
	output logic                             conv_re,
	output logic [rid_pkg::SLOT_W-1:0]       conv_raddr,
	input  logic [rid_pkg::CONV_BITS-1:0]    conv_rdata,
	output logic                             ring_we,
	output logic [rid_pkg::RING_AW-1:0]      ring_waddr,
	output logic [rid_pkg::ID_BITS-1:0]      ring_wdata,
	output logic                             ring_re,
	output logic [rid_pkg::RING_AW-1:0]      ring_raddr,
	input  logic [rid_pkg::ID_BITS-1:0]      ring_rdata,
	output logic                             res_valid,
	output rid_pkg::result_t                 res,
	input  logic                             res_free
);

	localparam int N  = rid_pkg::POOL_SLOTS;
	localparam int SW = rid_pkg::SLOT_W;
	localparam int RW = rid_pkg::RANK_W;
	localparam int PW = rid_pkg::POS_W;
	localparam int FW = rid_pkg::FILL_W;
	localparam int AW = rid_pkg::RING_AW;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CSCAN = 6'b000010,
		ST_TOUCH = 6'b000100,
		ST_RSCAN = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [rid_pkg::CONV_BITS-1:0] conv_q;
	logic [rid_pkg::ID_BITS-1:0]   id_q;
	logic [SW:0]                   ci_q;
	logic [SW-1:0]                 cidx_s1;
	logic                          crd_s1;
	logic                          hit_q;
	logic [SW-1:0]                 slot_q;
	logic [FW-1:0]                 ri_q;
	logic                          rrd_s1;
	logic                          dup_q;
	logic                          valid_q [N];
	logic [RW-1:0]                 rank_q  [N];
	logic [FW-1:0]                 fill_q  [N];
	logic [PW-1:0]                 pos_q   [N];

	logic          free_any;
	logic [SW-1:0] free_idx;
	logic [SW-1:0] lru_idx;
	logic          conv_match;
	logic          ring_match;
	logic [FW-1:0] fill_cur;
	logic [PW-1:0] pos_cur;
	logic [RW-1:0] rank_cur;
	logic [AW-1:0] ring_base;
	logic          ci_end;
	logic          ri_end;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		lru_idx  = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
			if (rank_q[i] == RW'(N - 1)) begin
				lru_idx = SW'(i);
			end
		end
	end

	assign fill_cur   = fill_q[slot_q];
	assign pos_cur    = pos_q[slot_q];
	assign rank_cur   = rank_q[slot_q];
	assign ring_base  = AW'(slot_q) * AW'(rid_pkg::RING_DEPTH);
	assign ci_end     = (ci_q == (SW + 1)'(N));
	assign ri_end     = (ri_q == fill_cur);
	assign conv_match = crd_s1 && valid_q[cidx_s1] && (conv_rdata == conv_q);
	assign ring_match = rrd_s1 && (ring_rdata == id_q);

	assign in_ready   = (state_q == ST_IDLE);
	assign conv_re    = (state_q == ST_CSCAN) && !ci_end;
	assign conv_raddr = ci_q[SW-1:0];
	assign conv_we    = (state_q == ST_TOUCH) && !hit_q;
	assign conv_waddr = slot_q;
	assign conv_wdata = conv_q;
	assign ring_re    = (state_q == ST_RSCAN) && !ring_match && !ri_end;
	assign ring_raddr = ring_base + AW'(ri_q);
	assign ring_we    = (state_q == ST_WRITE);
	assign ring_waddr = ring_base + AW'(pos_cur);
	assign ring_wdata = id_q;

	assign res_valid      = (state_q == ST_DONE);
	assign res.dup        = dup_q;
	assign res.slot       = slot_q;
	assign res.reassigned = !hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			conv_q  <= '0;
			id_q    <= '0;
			ci_q    <= '0;
			cidx_s1 <= '0;
			crd_s1  <= 1'b0;
			hit_q   <= 1'b0;
			slot_q  <= '0;
			ri_q    <= '0;
			rrd_s1  <= 1'b0;
			dup_q   <= 1'b0;
			for (int i = 0; i < N; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= RW'(i);
				fill_q[i]  <= '0;
				pos_q[i]   <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						conv_q  <= conv_in;
						id_q    <= id_in;
						ci_q    <= '0;
						crd_s1  <= 1'b0;
						state_q <= ST_CSCAN;
					end
				end
				ST_CSCAN: begin
					if (conv_match) begin
						hit_q   <= 1'b1;
						slot_q  <= cidx_s1;
						crd_s1  <= 1'b0;
						state_q <= ST_TOUCH;
					end else if (ci_end) begin
						hit_q   <= 1'b0;
						slot_q  <= free_any ? free_idx : lru_idx;
						crd_s1  <= 1'b0;
						state_q <= ST_TOUCH;
					end else begin
						crd_s1  <= 1'b1;
						cidx_s1 <= ci_q[SW-1:0];
						ci_q    <= ci_q + 1'b1;
					end
				end
				ST_TOUCH: begin
					for (int i = 0; i < N; i++) begin
						if (rank_q[i] < rank_cur) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					rank_q[slot_q] <= '0;
					if (!hit_q) begin
						valid_q[slot_q] <= 1'b1;
						fill_q[slot_q]  <= '0;
						pos_q[slot_q]   <= '0;
					end
					ri_q    <= '0;
					rrd_s1  <= 1'b0;
					state_q <= ST_RSCAN;
				end
				ST_RSCAN: begin
					if (ring_match) begin
						dup_q   <= 1'b1;
						rrd_s1  <= 1'b0;
						state_q <= ST_DONE;
					end else if (ri_end) begin
						dup_q   <= 1'b0;
						rrd_s1  <= 1'b0;
						state_q <= ST_WRITE;
					end else begin
						rrd_s1 <= 1'b1;
						ri_q   <= ri_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (pos_cur == PW'(rid_pkg::RING_DEPTH - 1)) begin
						pos_q[slot_q] <= '0;
					end else begin
						pos_q[slot_q] <= pos_cur + 1'b1;
					end
					if (fill_cur != FW'(rid_pkg::RING_DEPTH)) begin
						fill_q[slot_q] <= fill_cur + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/recent_id_dedup_pool_core.sv
// recent-id duplicate filter over a pool of conversation rings
// slave side: one beat carries a conversation tag and a message tag; the block
//   finds or places the conversation in its slot pool, then searches that
//   slot's ring of recent message ids and records the id when it is new
// master side: one beat per input beat with the duplicate flag, the slot that
//   serves the conversation and a flag that the slot was newly assigned
// sequence: the beat is taken, the tag scan runs through the slot memory, the
//   age ranks are updated, the ring scan reads the slot's filled entries
//   (stopping early on a match), the ring write records a new id (skipped for
//   a duplicate) and the result moves into the output register; the ring scan
//   is paced by the ring memory port, which gives one read per cycle
// throughput: one item at a time; s_tready is high only while the sequencer
//   waits for a beat, and a new beat is taken while the last result still
//   sits in the output register
// reset: all slots free, age ranks in slot order, all rings empty; no clearing
//   pass is needed since unwritten entries are never compared
// stall: a held result keeps m_tvalid and m_tdata stable; the next item runs
//   its scans and then waits until the output register frees up
module recent_id_dedup_pool_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// conversation_tag [63:0], message_tag [127:64]
	input  logic [rid_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// is_duplicate [0], slot_index [3:1], slot_reassigned [4], zero [7:5]
	output logic [rid_pkg::OUT_W-1:0]   m_tdata
);

	logic                            conv_we;
	logic [rid_pkg::SLOT_W-1:0]      conv_waddr;
	logic [rid_pkg::CONV_BITS-1:0]   conv_wdata;
	logic                            conv_re;
	logic [rid_pkg::SLOT_W-1:0]      conv_raddr;
	logic [rid_pkg::CONV_BITS-1:0]   conv_rdata;
	logic                            ring_we;
	logic [rid_pkg::RING_AW-1:0]     ring_waddr;
	logic [rid_pkg::ID_BITS-1:0]     ring_wdata;
	logic                            ring_re;
	logic [rid_pkg::RING_AW-1:0]     ring_raddr;
	logic [rid_pkg::ID_BITS-1:0]     ring_rdata;
	logic                            res_valid;
	rid_pkg::result_t                res;
	logic                            res_free;
	logic                            out_valid_q;
	logic [rid_pkg::OUT_W-1:0]       out_data_q;

	assign res_free = !out_valid_q || m_tready;

	rid_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.conv_in    (s_tdata[rid_pkg::CONV_BITS-1:0]),
		.id_in      (s_tdata[rid_pkg::CONV_BITS +: rid_pkg::ID_BITS]),
		.conv_we    (conv_we),
		.conv_waddr (conv_waddr),
		.conv_wdata (conv_wdata),
		.conv_re    (conv_re),
		.conv_raddr (conv_raddr),
		.conv_rdata (conv_rdata),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_re    (ring_re),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.res_valid  (res_valid),
		.res        (res),
		.res_free   (res_free)
	);

	rid_ram #(
		.DEPTH (rid_pkg::POOL_SLOTS),
		.WIDTH (rid_pkg::CONV_BITS)
	) u_conv_ram (
		.clk   (clk),
		.we    (conv_we),
		.waddr (conv_waddr),
		.wdata (conv_wdata),
		.re    (conv_re),
		.raddr (conv_raddr),
		.rdata (conv_rdata)
	);

	rid_ram #(
		.DEPTH (rid_pkg::RING_WORDS),
		.WIDTH (rid_pkg::ID_BITS)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (res_valid && res_free) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {3'b000, res.reassigned,
					rid_pkg::SLOT_OUT_W'(res.slot), res.dup};
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### rtl/core/rid_checker.sv
module rid_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [rid_pkg::OUT_W-1:0] m_tdata
);

	// a held result beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// no result beat out of reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result beat valid during reset");

	// one item in flight: ready drops right after a beat is taken
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while busy");

	// a result cannot appear the cycle after an input beat
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result beat too early");

	// padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:5] == 3'b000)
		else $error("padding bits set in result beat");

endmodule

bind recent_id_dedup_pool_core rid_checker u_rid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
